### src/hkrd_pkg.sv
package hkrd_pkg;

	localparam int INPUT_SLOTS = 6;
	localparam int MOD_BITS = 8;
	localparam logic [7:0] USAGE_BASE_RESET = 8'd224;

	typedef struct packed {
		logic [7:0] report_modifiers;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic       event_down;
		logic [7:0] event_modifiers;
		logic [7:0] event_key;
		logic       event_last;
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic advance;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bit_set;
		logic at_end;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] slot_of(input report_t r, input int i);
		logic [7:0] k;
		case (i)
			0: k = r.key_slot_0;
			1: k = r.key_slot_1;
			2: k = r.key_slot_2;
			3: k = r.key_slot_3;
			4: k = r.key_slot_4;
			5: k = r.key_slot_5;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

### src/hkrd_ctrl.sv
module hkrd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hkrd_pkg::sts_t sts,
	output hkrd_pkg::cmd_t cmd
);
	import hkrd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.advance = !sts.bit_set || sts.out_free;
				cmd.emit = sts.bit_set && sts.out_free;
				if (cmd.advance && sts.at_end) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/hkrd_dp.sv
module hkrd_dp #(
	parameter int KEY_SLOTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hkrd_pkg::report_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output hkrd_pkg::event_t  out_data,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  hkrd_pkg::cmd_t    cmd,
	output hkrd_pkg::sts_t    sts
);
	import hkrd_pkg::*;

	localparam int POS = 2 * KEY_SLOTS + MOD_BITS;
	localparam int IW = $clog2(POS);
	localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	logic [7:0]     prev_keys_q [KEY_SLOTS];
	logic [7:0]     new_keys_q  [KEY_SLOTS];
	logic [7:0]     in_keys     [KEY_SLOTS];
	logic [7:0]     prev_mods_q;
	logic [7:0]     new_mods_q;
	logic [7:0]     base_q;
	logic [POS-1:0] pending_q;
	logic [POS-1:0] pending_d;
	logic [POS-1:0] idx_hot;
	logic [IW-1:0]  idx_q;
	logic [IW-1:0]  dn_off;
	logic [IW-1:0]  md_off;
	logic [SW-1:0]  up_slot;
	logic [SW-1:0]  dn_slot;
	logic [2:0]     mb;
	logic [7:0]     hi_mask;
	event_t         evt;
	event_t         out_q;
	logic           out_valid_q;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			in_keys[i] = (i < INPUT_SLOTS) ? slot_of(in_data, i) : 8'd0;
		end
	end

	always_comb begin
		logic hit_up;
		logic hit_dn;
		pending_d = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			hit_up = 1'b0;
			hit_dn = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				hit_up = hit_up | (in_keys[j] == prev_keys_q[i]);
				hit_dn = hit_dn | (prev_keys_q[j] == in_keys[i]);
			end
			pending_d[i] = (prev_keys_q[i] != 8'd0) && !hit_up;
			pending_d[KEY_SLOTS + MOD_BITS + i] = (in_keys[i] != 8'd0) && !hit_dn;
		end
		for (int j = 0; j < MOD_BITS; j++) begin
			pending_d[KEY_SLOTS + j] = prev_mods_q[MOD_BITS - 1 - j]
				^ in_data.report_modifiers[MOD_BITS - 1 - j];
		end
	end

	always_comb begin
		for (int p = 0; p < POS; p++) begin
			idx_hot[p] = (idx_q == IW'(p));
		end
	end

	assign up_slot = idx_q[SW-1:0];
	assign dn_off  = idx_q - IW'(KEY_SLOTS + MOD_BITS);
	assign dn_slot = dn_off[SW-1:0];
	assign md_off  = idx_q - IW'(KEY_SLOTS);
	assign mb      = 3'd7 - md_off[2:0];
	assign hi_mask = 8'hFF << mb;

	always_comb begin
		evt.event_last = ((pending_q & ~idx_hot) == '0);
		if (idx_q < IW'(KEY_SLOTS)) begin
			evt.event_down      = 1'b0;
			evt.event_modifiers = prev_mods_q;
			evt.event_key       = prev_keys_q[up_slot];
		end else if (idx_q < IW'(KEY_SLOTS + MOD_BITS)) begin
			evt.event_down      = new_mods_q[mb];
			evt.event_modifiers = (prev_mods_q & ~hi_mask) | (new_mods_q & hi_mask);
			evt.event_key       = base_q + {5'd0, mb};
		end else begin
			evt.event_down      = 1'b1;
			evt.event_modifiers = new_mods_q;
			evt.event_key       = new_keys_q[dn_slot];
		end
	end

	assign sts.bit_set  = |(pending_q & idx_hot);
	assign sts.at_end   = (idx_q == IW'(POS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			base_q      <= USAGE_BASE_RESET;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			pending_q   <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (cmd.load) begin
				pending_q <= pending_d;
				idx_q     <= '0;
			end else if (cmd.advance) begin
				pending_q <= pending_q & ~idx_hot;
				idx_q     <= idx_q + IW'(1);
			end
			if (cmd.finish) begin
				prev_mods_q <= new_mods_q;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					prev_keys_q[i] <= new_keys_q[i];
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_mods_q <= in_data.report_modifiers;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				new_keys_q[i] <= in_keys[i];
			end
		end
		if (cmd.emit) begin
			out_q <= evt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/hid_keyboard_report_diff_top.sv
// An accepted report is scanned, and each event word is held in the output register.
// A new report is taken only in idle, once the last scan ends; the scan visits every
//   key-up slot, modifier bit and key-down slot once, one per cycle while the output is free.
// Output backpressure holds the scan on a pending event; the output register frees the input.
// Reset: stored report cleared to no keys and no modifiers, usage base set to 224, no word valid.
module hid_keyboard_report_diff_top #(
	parameter int KEY_SLOTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hkrd_pkg::report_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output hkrd_pkg::event_t  out_data,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata
);
	import hkrd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hkrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hkrd_dp #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### src/hkrd_checker.sv
module hkrd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input hkrd_pkg::event_t  out_data
);
	import hkrd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("event word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("report accepted during scan");

	a_reset_clean: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && in_ready)
		else $error("block not idle after reset");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.event_last |-> !in_ready)
		else $error("scan ended without last flag");

endmodule

bind hid_keyboard_report_diff_top hkrd_checker u_hkrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
